@@ rtl/core/jbas_pkg.sv @@
// Shared types, widths and constant-divide helpers for the Jacobi box average sweep unit.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package jbas_pkg;

  localparam int CELL_W           = 24;
  localparam int COL_SUM_W        = 26;
  localparam int SUM_W            = 28;
  localparam int MAG_W            = 27;
  localparam int RECIP_W          = 31;
  localparam int RECIP_SHIFT      = 32;
  localparam int PROD_W           = MAG_W + RECIP_W;
  localparam int Q0_W             = 26;
  localparam int QD_W             = 30;
  localparam int DIV_CONST_W      = 4;
  localparam int GRID_W           = 12;
  localparam int TARGET_W         = 23;
  localparam int CFG_DATA_W       = 23;
  localparam int CFG_INDEX_W      = 1;
  localparam int GRID_MIN         = 3;
  localparam int GRID_SIZE_RESET  = 2000;
  localparam int TARGET_RESET     = 3277;
  localparam int MAX_GRID_DEFAULT = 2048;
  localparam int QUEUE_DEPTH      = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GRID_SIZE     = 1'b0,
    REG_TARGET_CHANGE = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_BY_4,
    DIV_BY_6,
    DIV_BY_9
  } div_sel_t;

  // One cell to average: exact neighborhood sum, old value, divisor and
  // a flag that pins the cell to its old value.
  typedef struct packed {
    logic signed [SUM_W-1:0]  sum;
    logic signed [CELL_W-1:0] old_value;
    div_sel_t                 div;
    logic                     keep;
  } cell_job_t;

  // lane[0] is the cell one column back, lane[1] the last cell of a row.
  typedef struct packed {
    cell_job_t [1:0] lane;
    logic            has_second;
    logic            done;
  } job_t;

  // floor(2^32 / d); quotient estimate is exact or one low for |x| < 2^27
  function automatic logic [RECIP_W-1:0] div_recip(input div_sel_t d);
    case (d)
      DIV_BY_4: return 31'd1073741824;
      DIV_BY_6: return 31'd715827882;
      DIV_BY_9: return 31'd477218588;
      default:  return 31'd1073741824;
    endcase
  endfunction

  function automatic logic [DIV_CONST_W-1:0] div_const(input div_sel_t d);
    case (d)
      DIV_BY_4: return 4'd4;
      DIV_BY_6: return 4'd6;
      DIV_BY_9: return 4'd9;
      default:  return 4'd4;
    endcase
  endfunction

  // q * d by shift and add
  function automatic logic [QD_W-1:0] div_times(input logic [Q0_W-1:0] q,
                                                input div_sel_t d);
    logic [QD_W-1:0] qe;
    qe = QD_W'(q);
    case (d)
      DIV_BY_4: return qe << 2;
      DIV_BY_6: return (qe << 2) + (qe << 1);
      DIV_BY_9: return (qe << 3) + qe;
      default:  return qe << 2;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/jbas_front.sv @@
// Front end: column window, row and column counters, neighborhood sums and job classification.
// Depends on jbas_pkg.
`default_nettype none

module jbas_front #(
  parameter int MAX_GRID = jbas_pkg::MAX_GRID_DEFAULT,
  parameter int COORD_W  = $clog2(MAX_GRID)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                accept,
  input  wire logic signed [jbas_pkg::CELL_W-1:0]  above_cell,
  input  wire logic signed [jbas_pkg::CELL_W-1:0]  centre_cell,
  input  wire logic signed [jbas_pkg::CELL_W-1:0]  below_cell,
  input  wire logic        [jbas_pkg::GRID_W-1:0]  grid_size,
  output logic                                     job_valid,
  output jbas_pkg::job_t                           job,
  output logic             [COORD_W-1:0]           job_row,
  output logic             [COORD_W-1:0]           job_col
);
  import jbas_pkg::*;

  logic signed [CELL_W-1:0]    window_cells [6];
  logic        [COORD_W-1:0]   row_counter;
  logic        [COORD_W-1:0]   column_counter;
  logic        [GRID_W-1:0]    n_sat;
  logic        [GRID_W-1:0]    last_index;
  logic                        top_row;
  logic                        bottom_row;
  logic                        last_col;
  logic                        has_left;
  logic                        rows3;
  logic signed [COL_SUM_W-1:0] sum_l;
  logic signed [COL_SUM_W-1:0] sum_m;
  logic signed [COL_SUM_W-1:0] sum_r;

  function automatic logic signed [COL_SUM_W-1:0] col_sum(
    input logic top, input logic bot,
    input logic signed [CELL_W-1:0] a, input logic signed [CELL_W-1:0] m,
    input logic signed [CELL_W-1:0] b);
    logic signed [COL_SUM_W-1:0] s;
    s = COL_SUM_W'(m);
    if (!top) s = s + COL_SUM_W'(a);
    if (!bot) s = s + COL_SUM_W'(b);
    return s;
  endfunction

  always_comb begin
    if (grid_size < GRID_W'(GRID_MIN)) begin
      n_sat = GRID_W'(GRID_MIN);
    end else if (grid_size > GRID_W'(MAX_GRID)) begin
      n_sat = GRID_W'(MAX_GRID);
    end else begin
      n_sat = grid_size;
    end
    last_index = n_sat - GRID_W'(1);
    top_row    = (row_counter == '0);
    bottom_row = (GRID_W'(row_counter) >= last_index);
    last_col   = (GRID_W'(column_counter) >= last_index);
    has_left   = (column_counter >= COORD_W'(2));
    rows3      = !top_row && !bottom_row;

    sum_l = has_left ? col_sum(top_row, bottom_row, window_cells[0], window_cells[1],
                               window_cells[2]) : '0;
    sum_m = col_sum(top_row, bottom_row, window_cells[3], window_cells[4], window_cells[5]);
    sum_r = col_sum(top_row, bottom_row, above_cell, centre_cell, below_cell);

    job.lane[0].sum       = SUM_W'(sum_l) + SUM_W'(sum_m) + SUM_W'(sum_r);
    job.lane[0].old_value = window_cells[4];
    if (rows3 && has_left) begin
      job.lane[0].div = DIV_BY_9;
    end else if (rows3 || has_left) begin
      job.lane[0].div = DIV_BY_6;
    end else begin
      job.lane[0].div = DIV_BY_4;
    end
    // sink corner holds its value
    job.lane[0].keep      = top_row && (column_counter == COORD_W'(1));

    job.lane[1].sum       = SUM_W'(sum_m) + SUM_W'(sum_r);
    job.lane[1].old_value = centre_cell;
    job.lane[1].div       = rows3 ? DIV_BY_6 : DIV_BY_4;
    // source corner holds its value
    job.lane[1].keep      = bottom_row;

    job.has_second = last_col;
    job.done       = bottom_row;

    job_valid = accept && (column_counter != '0);
    job_row   = row_counter;
    job_col   = column_counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter    <= '0;
      column_counter <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_counter <= '0;
        if (bottom_row) begin
          row_counter <= '0;
        end else begin
          row_counter <= row_counter + COORD_W'(1);
        end
      end else begin
        column_counter <= column_counter + COORD_W'(1);
      end
    end
  end

  // advance the two-column window
  always_ff @(posedge clk) begin
    if (accept) begin
      window_cells[0] <= window_cells[3];
      window_cells[1] <= window_cells[4];
      window_cells[2] <= window_cells[5];
      window_cells[3] <= above_cell;
      window_cells[4] <= centre_cell;
      window_cells[5] <= below_cell;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/jbas_job_queue.sv @@
// Short register queue of jobs between front and back ends.
// Depends on jbas_pkg for the default depth.
`default_nettype none

module jbas_job_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = jbas_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] head_data,
  output logic                  head_valid
);
  import jbas_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/jbas_back.sv @@
// Back end: two-lane constant divide pipeline, change and running maximum, result register.
// Depends on jbas_pkg.
`default_nettype none

module jbas_back #(
  parameter int COORD_W = 11
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic        [jbas_pkg::TARGET_W-1:0] target_change,
  input  wire logic                                head_valid,
  input  wire jbas_pkg::job_t                      head_job,
  input  wire logic        [COORD_W-1:0]           head_row,
  input  wire logic        [COORD_W-1:0]           head_col,
  output logic                                     head_pop,
  input  wire logic                                pop,
  output logic                                     empty,
  output logic signed [jbas_pkg::CELL_W-1:0]       new_value,
  output logic        [COORD_W-1:0]                cell_row,
  output logic        [COORD_W-1:0]                cell_column,
  output logic        [jbas_pkg::CELL_W-1:0]       cell_change,
  output logic        [jbas_pkg::CELL_W-1:0]       frame_max_change,
  output logic                                     last_of_item,
  output logic                                     frame_done,
  output logic                                     converged
);
  import jbas_pkg::*;

  logic adv;

  // stage 0: magnitude and sign
  logic               s0_v;
  job_t               s0_job;
  logic [COORD_W-1:0] s0_row, s0_col;
  logic [MAG_W-1:0]   s0_mag [2];
  logic               s0_neg [2];
  // stage 1: quotient estimate
  logic               s1_v;
  job_t               s1_job;
  logic [COORD_W-1:0] s1_row, s1_col;
  logic [MAG_W-1:0]   s1_mag [2];
  logic               s1_neg [2];
  logic [Q0_W-1:0]    s1_q0  [2];
  // stage 2: corrected quotient
  logic               s2_v;
  job_t               s2_job;
  logic [COORD_W-1:0] s2_row, s2_col;
  logic               s2_neg [2];
  logic [CELL_W-1:0]  s2_q   [2];
  // stage 3: new value and change
  logic               s3_v;
  job_t               s3_job;
  logic [COORD_W-1:0] s3_row, s3_col;
  logic signed [CELL_W-1:0] s3_new [2];
  logic [CELL_W-1:0]  s3_change [2];
  // result register holding one or two cells
  logic               out_valid;
  logic               out_sel;
  logic               out_has_b;
  logic               out_done;
  logic               out_conv;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col    [2];
  logic signed [CELL_W-1:0] out_new [2];
  logic [CELL_W-1:0]  out_change [2];
  logic [CELL_W-1:0]  out_max    [2];
  logic [CELL_W-1:0]  running_max_change;

  logic [MAG_W-1:0]         mag_c     [2];
  logic [PROD_W-1:0]        prod_c    [2];
  logic [QD_W-1:0]          qd_c      [2];
  logic [QD_W-1:0]          rem_c     [2];
  logic [Q0_W-1:0]          q_c       [2];
  logic signed [CELL_W:0]   sq_c      [2];
  logic signed [CELL_W-1:0] new_c     [2];
  logic signed [CELL_W:0]   diff_c    [2];
  logic [CELL_W-1:0]        change_c  [2];
  logic [CELL_W-1:0]        max_a;
  logic [CELL_W-1:0]        max_b;

  assign adv      = !out_valid || (pop && (out_sel || !out_has_b));
  assign head_pop = adv && head_valid;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mag_c[l]  = head_job.lane[l].sum[SUM_W-1] ? MAG_W'(-head_job.lane[l].sum)
                                                : MAG_W'(head_job.lane[l].sum);
      prod_c[l] = PROD_W'(s0_mag[l]) * PROD_W'(div_recip(s0_job.lane[l].div));
      qd_c[l]   = div_times(s1_q0[l], s1_job.lane[l].div);
      rem_c[l]  = QD_W'(s1_mag[l]) - qd_c[l];
      q_c[l]    = (rem_c[l] >= QD_W'(div_const(s1_job.lane[l].div))) ?
                  s1_q0[l] + Q0_W'(1) : s1_q0[l];
      sq_c[l]   = s2_neg[l] ? -$signed({1'b0, s2_q[l]}) : $signed({1'b0, s2_q[l]});
      new_c[l]  = s2_job.lane[l].keep ? s2_job.lane[l].old_value : sq_c[l][CELL_W-1:0];
      diff_c[l] = (CELL_W+1)'(new_c[l]) - (CELL_W+1)'(s2_job.lane[l].old_value);
      change_c[l] = diff_c[l][CELL_W] ? CELL_W'(-diff_c[l]) : CELL_W'(diff_c[l]);
    end
    max_a = (s3_change[0] > running_max_change) ? s3_change[0] : running_max_change;
    max_b = (s3_change[1] > max_a) ? s3_change[1] : max_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v               <= 1'b0;
      s1_v               <= 1'b0;
      s2_v               <= 1'b0;
      s3_v               <= 1'b0;
      out_valid          <= 1'b0;
      out_sel            <= 1'b0;
      running_max_change <= '0;
    end else if (adv) begin
      s0_v      <= head_valid;
      s1_v      <= s0_v;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      out_valid <= s3_v;
      out_sel   <= 1'b0;
      if (s3_v) begin
        if (!s3_job.has_second) begin
          running_max_change <= max_a;
        end else if (s3_job.done) begin
          running_max_change <= '0;
        end else begin
          running_max_change <= max_b;
        end
      end
    end else if (pop && out_valid && !out_sel && out_has_b) begin
      out_sel <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_job <= head_job;
      s0_row <= head_row;
      s0_col <= head_col;
      s1_job <= s0_job;
      s1_row <= s0_row;
      s1_col <= s0_col;
      s2_job <= s1_job;
      s2_row <= s1_row;
      s2_col <= s1_col;
      s3_job <= s2_job;
      s3_row <= s2_row;
      s3_col <= s2_col;
      for (int l = 0; l < 2; l++) begin
        s0_mag[l]    <= mag_c[l];
        s0_neg[l]    <= head_job.lane[l].sum[SUM_W-1];
        s1_mag[l]    <= s0_mag[l];
        s1_neg[l]    <= s0_neg[l];
        s1_q0[l]     <= prod_c[l][RECIP_SHIFT +: Q0_W];
        s2_neg[l]    <= s1_neg[l];
        s2_q[l]      <= q_c[l][CELL_W-1:0];
        s3_new[l]    <= new_c[l];
        s3_change[l] <= change_c[l];
        out_new[l]    <= s3_new[l];
        out_change[l] <= s3_change[l];
      end
      out_has_b  <= s3_job.has_second;
      out_done   <= s3_job.done;
      out_conv   <= (max_b < CELL_W'(target_change));
      out_row    <= s3_row;
      out_col[0] <= s3_col - COORD_W'(1);
      out_col[1] <= s3_col;
      out_max[0] <= max_a;
      out_max[1] <= max_b;
    end
  end

  assign empty            = !out_valid;
  assign new_value        = out_new[out_sel];
  assign cell_row         = out_row;
  assign cell_column      = out_col[out_sel];
  assign cell_change      = out_change[out_sel];
  assign frame_max_change = out_max[out_sel];
  assign last_of_item     = out_sel || !out_has_b;
  assign frame_done       = out_sel && out_done;
  assign converged        = out_sel && out_done && out_conv;

endmodule

`default_nettype wire

@@ rtl/core/jacobi_box_average_sweep_unit.sv @@
// An accepted word passes through the job queue, the divide stages and the result register.
// Throughput: one word per cycle while the job queue has room; a word at the end of a row
// yields two results; the divide pipeline holds until the second is popped, absorbed by the
// 4-entry job queue between front and back ends. First word of a row yields no result.
// Reset (rst, synchronous): clears counters, queue, pipeline and running maximum; grid_size
// returns to 2000 and target_change to 3277. No clearing pass, usable the cycle after reset.
`default_nettype none

module jacobi_box_average_sweep_unit #(
  parameter int MAX_GRID = jbas_pkg::MAX_GRID_DEFAULT
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // input word side
  input  wire logic                                   push,
  output logic                                        full,
  input  wire logic signed [jbas_pkg::CELL_W-1:0]     above_cell,
  input  wire logic signed [jbas_pkg::CELL_W-1:0]     centre_cell,
  input  wire logic signed [jbas_pkg::CELL_W-1:0]     below_cell,
  // result side
  output logic                                        empty,
  input  wire logic                                   pop,
  output logic signed [jbas_pkg::CELL_W-1:0]          new_value,
  output logic        [$clog2(MAX_GRID)-1:0]          cell_row,
  output logic        [$clog2(MAX_GRID)-1:0]          cell_column,
  output logic        [jbas_pkg::CELL_W-1:0]          cell_change,
  output logic        [jbas_pkg::CELL_W-1:0]          frame_max_change,
  output logic                                        last_of_item,
  output logic                                        frame_done,
  output logic                                        converged,
  // configuration writes
  input  wire logic                                   cfg_write,
  input  wire logic        [jbas_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic        [jbas_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import jbas_pkg::*;

  localparam int COORD_W = $clog2(MAX_GRID);
  localparam int JOB_W   = $bits(job_t) + 2 * COORD_W;

  logic [GRID_W-1:0]   grid_size;
  logic [TARGET_W-1:0] target_change;

  logic               accept;
  logic               job_valid;
  job_t               job;
  logic [COORD_W-1:0] job_row;
  logic [COORD_W-1:0] job_col;
  logic               head_valid;
  logic               head_pop;
  logic [JOB_W-1:0]   head_data;
  job_t               head_job;
  logic [COORD_W-1:0] head_row;
  logic [COORD_W-1:0] head_col;

  // Configuration registers; user must write only while the block is idle; block does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size     <= GRID_W'(GRID_SIZE_RESET);
      target_change <= TARGET_W'(TARGET_RESET);
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_SIZE:     grid_size     <= cfg_data[GRID_W-1:0];
        REG_TARGET_CHANGE: target_change <= cfg_data[TARGET_W-1:0];
        default: ;
      endcase
    end
  end

  // Take a word whenever the job queue has room; the front end never stalls otherwise.
  assign accept = push && !full;

  // Front end: window, counters, sums and divisor choice, one word per cycle while the job queue has room.
  jbas_front #(
    .MAX_GRID (MAX_GRID),
    .COORD_W  (COORD_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .above_cell  (above_cell),
    .centre_cell (centre_cell),
    .below_cell  (below_cell),
    .grid_size   (grid_size),
    .job_valid   (job_valid),
    .job         (job),
    .job_row     (job_row),
    .job_col     (job_col)
  );

  // Decouple: full follows queue occupancy only, never the result side directly.
  jbas_job_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_valid),
    .push_data  ({job_row, job_col, job}),
    .full       (full),
    .pop        (head_pop),
    .head_data  (head_data),
    .head_valid (head_valid)
  );

  assign {head_row, head_col, head_job} = head_data;

  // Back end: divide by 4, 6 or 9 via reciprocal multiply, change, running max,
  // result register that serves one or two cells per job.
  jbas_back #(
    .COORD_W (COORD_W)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .target_change    (target_change),
    .head_valid       (head_valid),
    .head_job         (head_job),
    .head_row         (head_row),
    .head_col         (head_col),
    .head_pop         (head_pop),
    .pop              (pop),
    .empty            (empty),
    .new_value        (new_value),
    .cell_row         (cell_row),
    .cell_column      (cell_column),
    .cell_change      (cell_change),
    .frame_max_change (frame_max_change),
    .last_of_item     (last_of_item),
    .frame_done       (frame_done),
    .converged        (converged)
  );

  // The result side comes out of reset empty.
  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  // The final cell of a sweep closes its word.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_done) |-> last_of_item)
    else $error("frame_done on a result that is not last of its word");

  // Convergence is only reported on the final cell.
  a_conv_on_done: assert property (@(posedge clk) disable iff (rst)
    (!empty && converged) |-> frame_done)
    else $error("converged outside frame end");

  // The running maximum always covers the shown cell.
  a_max_covers_cell: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (frame_max_change >= cell_change))
    else $error("frame_max_change below cell_change");

endmodule

`default_nettype wire
